>>> rtl/kdsl_pkg.sv
// Shared types and constants for the key debounce / short-long press core.
// No dependencies; every other file refers to it by scoped names.
package kdsl_pkg;

  localparam int TIMER_BITS = 16;
  // compare width covers both the timer and the 16-bit long-press limit
  localparam int CMP_W      = (TIMER_BITS > 16) ? TIMER_BITS : 16;
  localparam int NUM_KEYS   = 4;

  // configuration register indexes
  typedef enum logic [2:0] {
    REG_DEBOUNCE_TICKS    = 3'd0,
    REG_LONG_PRESS_TICKS  = 3'd1,
    REG_SHORT_BEEP_COUNT  = 3'd2,
    REG_SHORT_BEEP_PERIOD = 3'd3,
    REG_LONG_BEEP_COUNT   = 3'd4,
    REG_LONG_BEEP_PERIOD  = 3'd5
  } reg_idx_t;

  localparam logic [7:0]  RST_DEBOUNCE_TICKS    = 8'd5;
  localparam logic [15:0] RST_LONG_PRESS_TICKS  = 16'd700;
  localparam logic [7:0]  RST_SHORT_BEEP_COUNT  = 8'd1;
  localparam logic [15:0] RST_SHORT_BEEP_PERIOD = 16'd30;
  localparam logic [7:0]  RST_LONG_BEEP_COUNT   = 8'd2;
  localparam logic [15:0] RST_LONG_BEEP_PERIOD  = 16'd50;

  typedef enum logic [1:0] {
    MARK_NONE  = 2'd0,
    MARK_SHORT = 2'd1,
    MARK_LONG  = 2'd2
  } mark_t;

  typedef struct packed {
    logic [7:0]  debounce_ticks;
    logic [15:0] long_press_ticks;
    logic [7:0]  short_beep_count;
    logic [15:0] short_beep_period;
    logic [7:0]  long_beep_count;
    logic [15:0] long_beep_period;
  } cfg_t;

  // key levels active low; bit 0 up, 1 down, 2 left, 3 right
  typedef struct packed {
    logic [NUM_KEYS-1:0] level;
    logic [NUM_KEYS-1:0] ack_mask;
  } item_t;

  typedef struct packed {
    logic [1:0]  up_mark;
    logic [1:0]  down_mark;
    logic [1:0]  left_mark;
    logic [1:0]  right_mark;
    logic        beep_request;
    logic [7:0]  beep_count;
    logic [15:0] beep_period;
  } res_t;

endpackage

>>> rtl/kdsl_cfg.sv
// Configuration register file for the press detector.
// Depends on kdsl_pkg (register indexes, reset values, cfg_t).
module kdsl_cfg (
  input  logic               clk,
  input  logic               rst_n,
  input  logic               cfg_we,
  input  logic [2:0]         cfg_index,
  input  logic [15:0]        cfg_wdata,
  output kdsl_pkg::cfg_t     cfg
);

  kdsl_pkg::cfg_t cfg_r;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      cfg_r.debounce_ticks    <= kdsl_pkg::RST_DEBOUNCE_TICKS;
      cfg_r.long_press_ticks  <= kdsl_pkg::RST_LONG_PRESS_TICKS;
      cfg_r.short_beep_count  <= kdsl_pkg::RST_SHORT_BEEP_COUNT;
      cfg_r.short_beep_period <= kdsl_pkg::RST_SHORT_BEEP_PERIOD;
      cfg_r.long_beep_count   <= kdsl_pkg::RST_LONG_BEEP_COUNT;
      cfg_r.long_beep_period  <= kdsl_pkg::RST_LONG_BEEP_PERIOD;
    end else if (cfg_we) begin
      unique case (cfg_index)
        kdsl_pkg::REG_DEBOUNCE_TICKS:    cfg_r.debounce_ticks    <= cfg_wdata[7:0];
        kdsl_pkg::REG_LONG_PRESS_TICKS:  cfg_r.long_press_ticks  <= cfg_wdata;
        kdsl_pkg::REG_SHORT_BEEP_COUNT:  cfg_r.short_beep_count  <= cfg_wdata[7:0];
        kdsl_pkg::REG_SHORT_BEEP_PERIOD: cfg_r.short_beep_period <= cfg_wdata;
        kdsl_pkg::REG_LONG_BEEP_COUNT:   cfg_r.long_beep_count   <= cfg_wdata[7:0];
        kdsl_pkg::REG_LONG_BEEP_PERIOD:  cfg_r.long_beep_period  <= cfg_wdata;
        default: ; // writes past the last register are dropped
      endcase
    end
  end

  assign cfg = cfg_r;

endmodule

>>> rtl/kdsl_scan.sv
// Scanner state (phase, press timer, held key, marks) and the per-tick rules.
// Depends on kdsl_pkg. Result is combinational; state updates when step is high.
module kdsl_scan (
  input  logic            clk,
  input  logic            rst_n,
  input  logic            step,
  input  kdsl_pkg::item_t item,
  input  kdsl_pkg::cfg_t  cfg,
  output kdsl_pkg::res_t  res
);

  typedef enum logic [1:0] {
    PH_IDLE = 2'd0,
    PH_DEB  = 2'd1,
    PH_QUAL = 2'd2
  } phase_t;

  localparam int TB = kdsl_pkg::TIMER_BITS;
  localparam int CW = kdsl_pkg::CMP_W;
  localparam int NK = kdsl_pkg::NUM_KEYS;

  phase_t              phase_r, phase_nxt;
  logic [TB-1:0]       timer_r, timer_nxt;
  logic [2:0]          held_r,  held_nxt;
  logic [NK-1:0][1:0]  marks_r, marks_nxt;

  logic [NK-1:0] pressed;
  logic          any_down;
  logic [CW-1:0] tmr_ext;
  logic          req;
  logic [7:0]    cnt;
  logic [15:0]   per;

  assign pressed  = ~item.level;
  assign any_down = |pressed;

  always_comb begin
    phase_nxt = phase_r;
    timer_nxt = timer_r;
    held_nxt  = held_r;
    marks_nxt = marks_r;
    req       = 1'b0;
    cnt       = '0;
    per       = '0;
    tmr_ext   = '0;

    for (int i = 0; i < NK; i++) begin
      if (item.ack_mask[i]) marks_nxt[i] = kdsl_pkg::MARK_NONE;
    end

    if (phase_r == PH_IDLE && any_down) phase_nxt = PH_DEB;

    if (phase_nxt != PH_IDLE) begin
      if (!(&timer_r)) timer_nxt = timer_r + 1'b1;   // saturating count
      tmr_ext = CW'(timer_nxt);

      if (phase_nxt == PH_DEB && tmr_ext >= CW'(cfg.debounce_ticks)) begin
        phase_nxt = PH_QUAL;
        // first pressed key in priority order; none pressed keeps old key
        if      (pressed[0]) held_nxt = 3'd1;
        else if (pressed[1]) held_nxt = 3'd2;
        else if (pressed[2]) held_nxt = 3'd3;
        else if (pressed[3]) held_nxt = 3'd4;
      end

      if (phase_nxt == PH_QUAL) begin
        if (tmr_ext < CW'(cfg.long_press_ticks)) begin
          if (!any_down) begin
            if (held_nxt >= 3'd1 && held_nxt <= 3'd4)
              marks_nxt[2'(held_nxt - 3'd1)] = kdsl_pkg::MARK_SHORT;
            timer_nxt = '0;
            phase_nxt = PH_IDLE;
            req = 1'b1;
            cnt = (cfg.short_beep_count == 8'd0) ? 8'd1 : cfg.short_beep_count;
            per = cfg.short_beep_period;
          end
        end else begin
          if (held_nxt >= 3'd1 && held_nxt <= 3'd4)
            marks_nxt[2'(held_nxt - 3'd1)] = kdsl_pkg::MARK_LONG;
          req = 1'b1;
          cnt = (cfg.long_beep_count == 8'd0) ? 8'd1 : cfg.long_beep_count;
          per = cfg.long_beep_period;
          if (!any_down) begin
            phase_nxt = PH_IDLE;
            timer_nxt = '0;
            marks_nxt = '0;
          end
        end
      end
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      phase_r <= PH_IDLE;
      timer_r <= '0;
      held_r  <= '0;
      marks_r <= '0;
    end else if (step) begin
      phase_r <= phase_nxt;
      timer_r <= timer_nxt;
      held_r  <= held_nxt;
      marks_r <= marks_nxt;
    end
  end

  assign res.up_mark      = marks_nxt[0];
  assign res.down_mark    = marks_nxt[1];
  assign res.left_mark    = marks_nxt[2];
  assign res.right_mark   = marks_nxt[3];
  assign res.beep_request = req;
  assign res.beep_count   = cnt;
  assign res.beep_period  = per;

endmodule

>>> rtl/key_debounce_short_long_press_core.sv
// Four-key debouncer with short/long press marks and beep requests.
// Path: input register, then result register; scanner next state is combinational.
// Throughput: one item per cycle while no stalled result holds the path.
// An item is taken while a finished result waits, held in the input register.
// Reset (rst_n low, synchronous): idle phase, timer and marks zero, registers to defaults.
// Depends on kdsl_pkg, kdsl_cfg, kdsl_scan.
module key_debounce_short_long_press_core (
  input  logic        clk,
  input  logic        rst_n,
  input  logic        cfg_we,
  input  logic [2:0]  cfg_index,
  input  logic [15:0] cfg_wdata,
  input  logic        in_valid,
  output logic        in_stall,
  input  logic        in_up_level,
  input  logic        in_down_level,
  input  logic        in_left_level,
  input  logic        in_right_level,
  input  logic [3:0]  in_ack_mask,
  output logic        out_valid,
  input  logic        out_stall,
  output logic [1:0]  out_up_mark,
  output logic [1:0]  out_down_mark,
  output logic [1:0]  out_left_mark,
  output logic [1:0]  out_right_mark,
  output logic        out_beep_request,
  output logic [7:0]  out_beep_count,
  output logic [15:0] out_beep_period
);

  kdsl_pkg::cfg_t  cfg;
  kdsl_pkg::item_t item_r;
  kdsl_pkg::res_t  res, res_r;
  logic            in_valid_r;
  logic            out_valid_r;
  logic            adv;
  logic            in_xfer;

  kdsl_cfg u_cfg (
    .clk       (clk),
    .rst_n     (rst_n),
    .cfg_we    (cfg_we),
    .cfg_index (cfg_index),
    .cfg_wdata (cfg_wdata),
    .cfg       (cfg)
  );

  kdsl_scan u_scan (
    .clk   (clk),
    .rst_n (rst_n),
    .step  (adv),
    .item  (item_r),
    .cfg   (cfg),
    .res   (res)
  );

  // held item moves on whenever the result register is free or draining
  assign adv      = in_valid_r && !(out_valid_r && out_stall);
  assign in_stall = in_valid_r && out_valid_r && out_stall;
  assign in_xfer  = in_valid && !in_stall;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      in_valid_r  <= 1'b0;
      out_valid_r <= 1'b0;
    end else begin
      if (in_xfer)  in_valid_r <= 1'b1;
      else if (adv) in_valid_r <= 1'b0;

      if (adv)             out_valid_r <= 1'b1;
      else if (!out_stall) out_valid_r <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (in_xfer) begin
      item_r.level    <= {in_right_level, in_left_level, in_down_level, in_up_level};
      item_r.ack_mask <= in_ack_mask;
    end
    if (adv) res_r <= res;
  end

  assign out_valid        = out_valid_r;
  assign out_up_mark      = res_r.up_mark;
  assign out_down_mark    = res_r.down_mark;
  assign out_left_mark    = res_r.left_mark;
  assign out_right_mark   = res_r.right_mark;
  assign out_beep_request = res_r.beep_request;
  assign out_beep_count   = res_r.beep_count;
  assign out_beep_period  = res_r.beep_period;

endmodule
